// ----- sv/connection_packet_classifier_assert.svh -----
// Assertion macros for the connection packet classifier.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CONNECTION_PACKET_CLASSIFIER_ASSERT_SVH
`define CONNECTION_PACKET_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpc: same-cycle check failed");
`define CPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpc: next-cycle check failed");
`else
`define CPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/cpc_pkg.sv -----
// Shared types and codes for the connection packet classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpc_pkg;

    localparam int HEADER_BYTES = 12;

    localparam logic [1:0] ACT_PACKET = 2'd0;
    localparam logic [1:0] ACT_OPEN   = 2'd1;
    localparam logic [1:0] ACT_CLOSE  = 2'd2;

    localparam logic [1:0] MT_REQUEST = 2'd0;
    localparam logic [1:0] MT_ACCEPT  = 2'd1;
    localparam logic [1:0] MT_ACK     = 2'd2;

    localparam logic [1:0] VERDICT_NONE      = 2'd0;
    localparam logic [1:0] VERDICT_PROCESSED = 2'd1;
    localparam logic [1:0] VERDICT_OWN       = 2'd2;

    localparam logic [1:0] ROUTE_NONE     = 2'd0;
    localparam logic [1:0] ROUTE_SEND     = 2'd1;
    localparam logic [1:0] ROUTE_RECV     = 2'd2;
    localparam logic [1:0] ROUTE_RECV_CON = 2'd3;

    localparam logic [2:0] CFG_OPEN_MODE   = 3'd0;
    localparam logic [2:0] CFG_LOCAL_ADDR  = 3'd1;
    localparam logic [2:0] CFG_LOCAL_CID   = 3'd2;
    localparam logic [2:0] CFG_REMOTE_ADDR = 3'd3;
    localparam logic [2:0] CFG_REMOTE_CID  = 3'd4;

    typedef struct packed {
        logic        open_mode;
        logic [31:0] local_addr;
        logic [15:0] local_cid;
        logic [31:0] remote_addr;
        logic [15:0] remote_cid;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  ip_header_words;
        logic [15:0] packet_length;
        logic        checksum_ok;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_cid;
        logic [15:0] dst_cid;
        logic [1:0]  msg_type;
    } item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  route;
        logic [15:0] payload_length;
        logic [1:0]  conn_state_out;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/cpc_cfg_regs.sv -----
// Configuration register file for the connection packet classifier.
// Depends on cpc_pkg.
`default_nettype none

module cpc_cfg_regs
    import cpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPEN_MODE:   cfg_reg.open_mode   <= cfg_wdata[0];
                CFG_LOCAL_ADDR:  cfg_reg.local_addr  <= cfg_wdata;
                CFG_LOCAL_CID:   cfg_reg.local_cid   <= cfg_wdata[15:0];
                CFG_REMOTE_ADDR: cfg_reg.remote_addr <= cfg_wdata;
                CFG_REMOTE_CID:  cfg_reg.remote_cid  <= cfg_wdata[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/cpc_conn.sv -----
// Connection state, learned peer and per-item classification logic.
// Depends on cpc_pkg and connection_packet_classifier_assert.svh.
`default_nettype none

`include "connection_packet_classifier_assert.svh"

module cpc_conn
    import cpc_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_BYTES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   res
);

    typedef enum logic [1:0] {
        ST_CLOSED      = 2'd0,
        ST_LISTEN      = 2'd1,
        ST_WAITING     = 2'd2,
        ST_ESTABLISHED = 2'd3
    } conn_state_t;

    conn_state_t state_reg, state_next;
    logic [31:0] peer_addr_reg, peer_addr_next;
    logic [15:0] peer_cid_reg, peer_cid_next;

    logic [5:0]  hbytes;
    logic [16:0] min_len;
    logic        short_hdr;
    logic        own_pkt;
    logic        exact;

    assign hbytes    = {item.ip_header_words, 2'b00};
    assign min_len   = 17'(hbytes) + 17'(HEADER_LEN);
    assign short_hdr = {1'b0, item.packet_length} < min_len;
    assign own_pkt   = (item.src_addr != item.dst_addr) && (item.src_addr == cfg.local_addr)
                       && (item.src_cid == cfg.local_cid);
    assign exact     = (item.src_addr == peer_addr_reg) && (item.dst_addr == cfg.local_addr)
                       && (item.src_cid == peer_cid_reg) && (item.dst_cid == cfg.local_cid);

    always_comb
    begin
        state_next     = state_reg;
        peer_addr_next = peer_addr_reg;
        peer_cid_next  = peer_cid_reg;
        res            = '0;
        unique case (item.action)
            ACT_OPEN:
            begin
                if (cfg.open_mode)
                begin
                    state_next     = ST_WAITING;
                    peer_addr_next = cfg.remote_addr;
                    peer_cid_next  = cfg.remote_cid;
                end
                else
                begin
                    state_next     = ST_LISTEN;
                    peer_addr_next = '0;
                    peer_cid_next  = '0;
                end
            end
            ACT_CLOSE:
            begin
                state_next     = ST_CLOSED;
                peer_addr_next = '0;
                peer_cid_next  = '0;
            end
            ACT_PACKET:
            begin
                if (short_hdr || !item.checksum_ok)
                begin
                    res.verdict = VERDICT_NONE;
                end
                else if (own_pkt)
                begin
                    res.verdict = VERDICT_OWN;
                end
                else
                begin
                    unique case (state_reg)
                        ST_ESTABLISHED:
                        begin
                            if (item.msg_type != MT_REQUEST && item.msg_type != MT_ACCEPT
                                && exact)
                            begin
                                res.verdict = VERDICT_PROCESSED;
                                res.route   = (item.msg_type == MT_ACK) ? ROUTE_SEND
                                                                        : ROUTE_RECV;
                            end
                        end
                        ST_LISTEN:
                        begin
                            if (item.msg_type == MT_REQUEST
                                && item.dst_addr == cfg.local_addr
                                && item.dst_cid == cfg.local_cid)
                            begin
                                peer_addr_next = item.src_addr;
                                peer_cid_next  = item.src_cid;
                                state_next     = ST_ESTABLISHED;
                                res.verdict    = VERDICT_PROCESSED;
                                res.route      = ROUTE_RECV_CON;
                            end
                        end
                        ST_WAITING:
                        begin
                            if (item.msg_type == MT_ACCEPT && exact)
                            begin
                                state_next  = ST_ESTABLISHED;
                                res.verdict = VERDICT_PROCESSED;
                                res.route   = ROUTE_SEND;
                            end
                        end
                        default:
                        begin
                            res.verdict = VERDICT_NONE;
                        end
                    endcase
                end
                if (res.route != ROUTE_NONE)
                begin
                    res.payload_length = item.packet_length - 16'(hbytes);
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        res.conn_state_out = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLOSED;
            peer_addr_reg <= '0;
            peer_cid_reg  <= '0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            peer_addr_reg <= peer_addr_next;
            peer_cid_reg  <= peer_cid_next;
        end
    end

    `CPC_ASSERT_IMP(a_route_needs_processed, clk, rst_n,
        step && res.route != ROUTE_NONE, res.verdict == VERDICT_PROCESSED)
    `CPC_ASSERT_IMP(a_closed_never_processes, clk, rst_n,
        step && state_reg == ST_CLOSED && item.action == ACT_PACKET,
        res.verdict != VERDICT_PROCESSED)
    `CPC_ASSERT_NXT(a_close_clears, clk, rst_n,
        step && item.action == ACT_CLOSE,
        state_reg == ST_CLOSED && peer_addr_reg == '0 && peer_cid_reg == '0)
    `CPC_ASSERT_NXT(a_own_keeps_state, clk, rst_n,
        step && item.action == ACT_PACKET && res.verdict == VERDICT_OWN,
        $stable(state_reg) && $stable(peer_addr_reg) && $stable(peer_cid_reg))

endmodule

`default_nettype wire

// ----- sv/connection_packet_classifier.sv -----
// An accepted item is held in item_reg; its result is registered into res_reg.
// Throughput: one transfer per cycle while m_tready holds; the input register frees while
// the result register is taken, so both sides stream without bubbles.
// Reset: valid flags clear, connection goes to closed, peer and configuration to zero.
// Depends on cpc_pkg, cpc_cfg_regs and cpc_conn.
`default_nettype none

module connection_packet_classifier
    import cpc_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_BYTES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ip_header_words[3:0], packet_length[19:4], checksum_ok[20], src_addr[52:21],
    // dst_addr[84:53], src_cid[100:85], dst_cid[116:101], zero fill[119:117]
    input  wire logic [119:0] s_tdata,
    // action[1:0], msg_type[3:2]
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // payload_length[15:0], conn_state_out[17:16], zero fill[23:18]
    output logic [23:0]       m_tdata,
    // verdict[1:0], route[3:2]
    output logic [3:0]        m_tuser
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item_reg;
    result_t res;
    result_t res_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    cpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign in_item.action          = s_tuser[1:0];
    assign in_item.msg_type        = s_tuser[3:2];
    assign in_item.ip_header_words = s_tdata[3:0];
    assign in_item.packet_length   = s_tdata[19:4];
    assign in_item.checksum_ok     = s_tdata[20];
    assign in_item.src_addr        = s_tdata[52:21];
    assign in_item.dst_addr        = s_tdata[84:53];
    assign in_item.src_cid         = s_tdata[100:85];
    assign in_item.dst_cid         = s_tdata[116:101];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    cpc_conn #(
        .HEADER_LEN (HEADER_LEN)
    ) u_conn (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_reg.conn_state_out, res_reg.payload_length};
    assign m_tuser  = {res_reg.route, res_reg.verdict};

endmodule

`default_nettype wire

// ----- tb/tb_connection_packet_classifier.sv -----
// Testbench for connection_packet_classifier: directed and random stream traffic,
// checked against a predictor of the connection state machine kept in this file.
// Depends on cpc_pkg and the connection_packet_classifier RTL.
`timescale 1ns / 1ps

module tb_connection_packet_classifier;
    import cpc_pkg::*;

    typedef enum logic [1:0] {ST_CLOSED, ST_LISTEN, ST_WAITING, ST_ESTABLISHED} conn_state_e;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] MT_DATA    = 2'd3;
    localparam int STALL_PCT   = 14;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 4;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [3:0]   m_tuser;

    connection_packet_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // connection tracker shadow
    cfg_t        shadow_cfg = '0;
    conn_state_e conn_st = ST_CLOSED;
    logic [31:0] peer_addr_q = '0;
    logic [15:0] peer_cid_q = '0;

    result_t     expected_results[$];
    bit          gaps_on = 1'b1;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_routed = 0;
    int          n_own = 0;
    int          n_errors = 0;
    int          idle_cycles = 0;

    function automatic result_t classify(item_t it);
        result_t     r;
        logic [16:0] need;
        logic [15:0] hdr_bytes;
        bit          from_peer;
        r = '0;
        hdr_bytes = {10'd0, it.ip_header_words, 2'b00};
        need = {1'b0, hdr_bytes} + 17'(HEADER_BYTES);
        from_peer = (it.src_addr == peer_addr_q) && (it.dst_addr == shadow_cfg.local_addr)
                    && (it.src_cid == peer_cid_q) && (it.dst_cid == shadow_cfg.local_cid);
        case (it.action)
            ACT_OPEN:
            begin
                if (shadow_cfg.open_mode)
                begin
                    conn_st = ST_WAITING;
                    peer_addr_q = shadow_cfg.remote_addr;
                    peer_cid_q = shadow_cfg.remote_cid;
                end
                else
                begin
                    conn_st = ST_LISTEN;
                    peer_addr_q = '0;
                    peer_cid_q = '0;
                end
            end
            ACT_CLOSE:
            begin
                conn_st = ST_CLOSED;
                peer_addr_q = '0;
                peer_cid_q = '0;
            end
            ACT_PACKET:
            begin
                if ({1'b0, it.packet_length} < need || !it.checksum_ok)
                    r.verdict = VERDICT_NONE;
                else if (it.src_addr != it.dst_addr && it.src_addr == shadow_cfg.local_addr
                         && it.src_cid == shadow_cfg.local_cid)
                    r.verdict = VERDICT_OWN;
                else if (conn_st == ST_ESTABLISHED)
                begin
                    if ((it.msg_type == MT_ACK || it.msg_type == MT_DATA) && from_peer)
                    begin
                        r.verdict = VERDICT_PROCESSED;
                        r.route = (it.msg_type == MT_ACK) ? ROUTE_SEND : ROUTE_RECV;
                    end
                end
                else if (conn_st == ST_LISTEN)
                begin
                    if (it.msg_type == MT_REQUEST && it.dst_addr == shadow_cfg.local_addr
                        && it.dst_cid == shadow_cfg.local_cid)
                    begin
                        peer_addr_q = it.src_addr;
                        peer_cid_q = it.src_cid;
                        conn_st = ST_ESTABLISHED;
                        r.verdict = VERDICT_PROCESSED;
                        r.route = ROUTE_RECV_CON;
                    end
                end
                else if (conn_st == ST_WAITING)
                begin
                    if (it.msg_type == MT_ACCEPT && from_peer)
                    begin
                        conn_st = ST_ESTABLISHED;
                        r.verdict = VERDICT_PROCESSED;
                        r.route = ROUTE_SEND;
                    end
                end
                if (r.route != ROUTE_NONE)
                    r.payload_length = it.packet_length - hdr_bytes;
            end
            default:
            begin
            end
        endcase
        r.conn_state_out = conn_st;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic item_t act(logic [1:0] a);
        item_t it;
        it.action = a;
        it.ip_header_words = 4'($urandom);
        it.packet_length = 16'($urandom);
        it.checksum_ok = 1'($urandom);
        it.src_addr = $urandom;
        it.dst_addr = $urandom;
        it.src_cid = 16'($urandom);
        it.dst_cid = 16'($urandom);
        it.msg_type = 2'($urandom);
        return it;
    endfunction

    // well-formed header: long enough, checksum good
    function automatic item_t pkt(logic [1:0] mt, logic [31:0] sa, logic [31:0] da,
                                  logic [15:0] sc, logic [15:0] dc);
        item_t it;
        int    need;
        it.action = ACT_PACKET;
        it.ip_header_words = 4'($urandom);
        need = it.ip_header_words * 4 + HEADER_BYTES;
        it.packet_length = 16'($urandom_range(need, 65535));
        it.checksum_ok = 1'b1;
        it.src_addr = sa;
        it.dst_addr = da;
        it.src_cid = sc;
        it.dst_cid = dc;
        it.msg_type = mt;
        return it;
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_cid();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic item_t next_stimulus();
        item_t it;
        int    roll;
        int    need;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            it = act(ACT_CLOSE);
        else if (roll < 5)
            it = act(ACT_OPEN);
        else if (roll < 6)
            it = act(ACT_UNUSED);
        else if (roll < 9)
            it = act(ACT_PACKET);
        else if (roll < 13)
            it = pkt(2'($urandom), shadow_cfg.local_addr, $urandom,
                     shadow_cfg.local_cid, 16'($urandom));
        else
        begin
            case (conn_st)
                ST_CLOSED:
                    it = act(ACT_OPEN);
                ST_LISTEN:
                    it = pkt(MT_REQUEST, $urandom, shadow_cfg.local_addr,
                             16'($urandom), shadow_cfg.local_cid);
                ST_WAITING:
                    it = pkt(MT_ACCEPT, peer_addr_q, shadow_cfg.local_addr,
                             peer_cid_q, shadow_cfg.local_cid);
                default:
                    it = pkt($urandom_range(0, 1) ? MT_ACK : MT_DATA, peer_addr_q,
                             shadow_cfg.local_addr, peer_cid_q, shadow_cfg.local_cid);
            endcase
            if (it.action == ACT_PACKET && roll < 25)
            begin
                case ($urandom_range(0, 4))
                    0: it.src_addr ^= 32'd1 << $urandom_range(0, 31);
                    1: it.dst_addr ^= 32'd1 << $urandom_range(0, 31);
                    2: it.src_cid ^= 16'd1 << $urandom_range(0, 15);
                    3: it.dst_cid ^= 16'd1 << $urandom_range(0, 15);
                    default: it.msg_type = 2'($urandom);
                endcase
            end
            else if (it.action == ACT_PACKET && roll < 33)
            begin
                need = it.ip_header_words * 4 + HEADER_BYTES;
                if ($urandom_range(0, 1))
                    it.checksum_ok = 1'b0;
                else
                    it.packet_length = 16'($urandom_range(0, need - 1));
            end
        end
        return it;
    endfunction

    // ---------------------------------------------------------------- bus tasks

    task automatic send_item(item_t it);
        if (gaps_on && $urandom_range(0, 99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, it.dst_cid, it.src_cid, it.dst_addr, it.src_addr,
                    it.checksum_ok, it.packet_length, it.ip_header_words};
        s_tuser <= {it.msg_type, it.action};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(classify(it));
        n_sent++;
    endtask

    task automatic idle_bus();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(cfg_t c);
        idle_bus();
        wait_drained();
        write_reg(CFG_OPEN_MODE, {31'd0, c.open_mode});
        write_reg(CFG_LOCAL_ADDR, c.local_addr);
        write_reg(CFG_LOCAL_CID, {16'd0, c.local_cid});
        write_reg(CFG_REMOTE_ADDR, c.remote_addr);
        write_reg(CFG_REMOTE_CID, {16'd0, c.remote_cid});
        shadow_cfg = c;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_closed_state();
        item_t it;
        send_item(pkt(MT_REQUEST, 32'h0000_0001, 32'h0, 16'h0001, 16'h0));
        send_item(act(ACT_UNUSED));
        // own packet is flagged even while closed
        send_item(pkt(MT_DATA, 32'h0, 32'h0A00_0001, 16'h0, 16'h1234));
        it = pkt(MT_ACK, 32'h0, 32'h0, 16'h0, 16'h0);
        send_item(it);
    endtask

    task automatic test_listen_handshake();
        cfg_t  c;
        item_t it;
        c = '0;
        c.open_mode = 1'b0;
        c.local_addr = 32'hFFFF_FFFF;
        c.local_cid = 16'hFFFF;
        c.remote_addr = 32'hFFFF_FFFF;
        c.remote_cid = 16'hFFFF;
        configure(c);
        send_item(act(ACT_OPEN));
        send_item(pkt(MT_REQUEST, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'h0000));
        send_item(pkt(MT_ACCEPT, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'hFFFF));
        // one byte short of the header minimum
        it = pkt(MT_REQUEST, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'hFFFF);
        it.ip_header_words = 4'hF;
        it.packet_length = 16'd71;
        send_item(it);
        it.packet_length = 16'hFFFF;
        it.checksum_ok = 1'b0;
        send_item(it);
        // exactly at the minimum: learns the peer
        it.packet_length = 16'd72;
        it.checksum_ok = 1'b1;
        send_item(it);
    endtask

    task automatic test_established_routing();
        item_t it;
        it = pkt(MT_DATA, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'hFFFF);
        it.ip_header_words = 4'h0;
        it.packet_length = 16'hFFFF;
        send_item(it);
        send_item(pkt(MT_ACK, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'hFFFF));
        send_item(pkt(MT_REQUEST, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'hFFFF));
        send_item(pkt(MT_ACCEPT, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0042, 16'hFFFF));
        send_item(pkt(MT_DATA, 32'hC0A8_0001, 32'hFFFF_FFFF, 16'h0043, 16'hFFFF));
        // source equals destination: not treated as own
        send_item(pkt(MT_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_item(pkt(MT_ACK, 32'hFFFF_FFFF, 32'hC0A8_0001, 16'hFFFF, 16'h0042));
        send_item(act(ACT_CLOSE));
    endtask

    task automatic test_connect_handshake();
        cfg_t c;
        c.open_mode = 1'b1;
        c.local_addr = 32'h8000_0001;
        c.local_cid = 16'h7FFF;
        c.remote_addr = 32'h0000_0000;
        c.remote_cid = 16'h0000;
        configure(c);
        send_item(act(ACT_OPEN));
        send_item(pkt(MT_ACCEPT, 32'h0000_0001, 32'h8000_0001, 16'h0000, 16'h7FFF));
        send_item(pkt(MT_ACK, 32'h0000_0000, 32'h8000_0001, 16'h0000, 16'h7FFF));
        send_item(pkt(MT_ACCEPT, 32'h0000_0000, 32'h8000_0001, 16'h0000, 16'h7FFF));
        send_item(act(ACT_CLOSE));
    endtask

    task automatic test_random_sessions(int n_sessions, int per_session);
        cfg_t c;
        for (int s = 0; s < n_sessions; s++)
        begin
            c.open_mode = 1'($urandom);
            c.local_addr = pick_addr();
            c.local_cid = pick_cid();
            c.remote_addr = pick_addr();
            c.remote_cid = pick_cid();
            configure(c);
            gaps_on = (s != n_sessions / 2);
            send_item(act(ACT_OPEN));
            for (int i = 0; i < per_session; i++)
            begin
                // sender holds off until the result queue is empty
                if (s == 2 && i == per_session / 2)
                begin
                    idle_bus();
                    wait_drained();
                end
                send_item(next_stimulus());
            end
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------- sink, checker, watchdog

    always @(posedge clk)
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= STALL_PCT);

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    result_t want_r;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                n_errors++;
            end
            else
            begin
                want_r = expected_results.pop_front();
                check_field("verdict", 16'(want_r.verdict), 16'(m_tuser[1:0]));
                check_field("route", 16'(want_r.route), 16'(m_tuser[3:2]));
                check_field("payload_length", want_r.payload_length, m_tdata[15:0]);
                check_field("conn_state", 16'(want_r.conn_state_out), 16'(m_tdata[17:16]));
                n_checked++;
                if (m_tuser[3:2] != ROUTE_NONE)
                    n_routed++;
                if (m_tuser[1:0] == VERDICT_OWN)
                    n_own++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_closed_state();
        test_listen_handshake();
        test_established_routing();
        test_connect_handshake();
        test_random_sessions(10, 100);
        idle_bus();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d input transfers over listen and connect sessions;", n_sent);
        $display("%0d results checked, %0d routed, %0d own packets", n_checked, n_routed,
                 n_own);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
